### hdl/msps_pkg.sv
package msps_pkg;

  // Averaging ring
  localparam int AVG_LENGTH      = 10;
  localparam int RING_AW         = $clog2(AVG_LENGTH);
  localparam int ADC_BITS        = 10;
  localparam int ADC_FULL_SCALE  = (1 << ADC_BITS) - 1;
  localparam int SUM_W           = $clog2(AVG_LENGTH * ADC_FULL_SCALE + 1);

  // Scaling
  localparam int SPEED_SPAN      = 198;
  localparam int ANGLE_SPAN      = 180;
  localparam int DC_DIVISOR      = 100;
  localparam int SOFT_PWM_PERIOD = 99;

  // Shared multiplier
  localparam int MUL_W           = 24;
  localparam int PROD_W          = 2 * MUL_W;
  localparam int SCALE_W         = 18;

  // Reciprocals for division by constants (exact over the operand ranges used)
  localparam int AVG_SHIFT       = 19;
  localparam int RECIP_AVG       = ((1 << AVG_SHIFT) + AVG_LENGTH - 1) / AVG_LENGTH;
  localparam int TICK_SHIFT      = 23;
  localparam int RECIP_ANGLE     = ((1 << TICK_SHIFT) + ANGLE_SPAN - 1) / ANGLE_SPAN;
  localparam int DC_SHIFT        = 30;
  localparam int RECIP_DC        = ((1 << DC_SHIFT) + DC_DIVISOR - 1) / DC_DIVISOR;

  typedef enum logic [0:0] {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_DC_PERIOD   = 1'b0,
    REG_SERVO_TICKS = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_AVG_S,
    ST_SCL_S,
    ST_AVG_A,
    ST_SCL_A,
    ST_TPD,
    ST_SERVO,
    ST_DC1,
    ST_DC2,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e        command;
    logic [9:0]  chan0_sample;
    logic [9:0]  chan1_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [7:0] speed_setting;
    logic [6:0]        abs_speed;
    logic [7:0]        abs_angle;
    logic signed [7:0] angle_setting;
    logic              dir_a;
    logic              dir_b;
    logic              standby_low;
    logic [15:0]       dc_pulse;
    logic [15:0]       servo_pulse;
    logic              led_on;
  } out_word_t;

  // x / ADC_FULL_SCALE with full scale = 2^ADC_BITS - 1: x = q0*2^n + lo
  // = q0*(2^n-1) + (q0+lo), and q0+lo stays below twice the divisor.
  function automatic logic [SCALE_W-ADC_BITS:0] div_full_scale(input logic [SCALE_W-1:0] x);
    logic [SCALE_W-ADC_BITS-1:0] q0;
    logic [ADC_BITS:0]           r;
    q0 = x[SCALE_W-1:ADC_BITS];
    r  = {1'b0, x[ADC_BITS-1:0]} + (ADC_BITS+1)'(q0);
    return {1'b0, q0} + ((r >= (ADC_BITS+1)'(ADC_FULL_SCALE)) ?
                         (SCALE_W-ADC_BITS+1)'(1) : (SCALE_W-ADC_BITS+1)'(0));
  endfunction

endpackage

### hdl/msps_ram.sv
module msps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/motor_servo_pwm_setpoint_unit.sv
// Motor and servo setpoint unit.
// Input words arrive on in_valid_i / in_stall_o: a sample word carries one
// ADC pair for the averaging rings, a tick word steps the LED soft PWM.
// Every accepted word yields exactly one result word on out_valid_o /
// out_stall_i with speed and angle setpoints, H-bridge direction bits,
// standby flag, DC and servo compare values and the LED state.
// One word is worked on at a time. The ring pair sits in a single RAM with
// registered read; a sample is read, updated and written back, then the
// setpoints go through one shared 24x24 multiplier, one product per cycle.
// A finished word waits in the output register while the receiver stalls;
// the next input word is taken meanwhile and its work stops only at the
// final step until the output register frees. Reset clears the control
// and held state but not the datapath registers; the rings read as zero
// through per-entry valid bits, so no clearing pass is needed. The APB
// port (pready tied high) holds the DC period and servo tick count; it
// must be written only while idle, which the block does not enforce.
module motor_servo_pwm_setpoint_unit
  import msps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [9:0]        ADC_MAX    = 10'(ADC_FULL_SCALE);
  localparam logic signed [9:0] SPEED_OFS  = 10'(SPEED_SPAN / 2);
  localparam logic signed [9:0] ANGLE_OFS  = 10'(ANGLE_SPAN / 2);
  localparam logic [6:0]        PWM_LAST   = 7'(SOFT_PWM_PERIOD - 1);

  // Configuration registers
  logic [15:0] dc_period_q, servo_ticks_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_period_q   <= 16'd1999;
      servo_ticks_q <= 16'd9000;
    end else if (cfg_we) begin
      unique case (reg_e'(paddr[2]))
        REG_DC_PERIOD:   dc_period_q   <= pwdata[15:0];
        REG_SERVO_TICKS: servo_ticks_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_DC_PERIOD:   prdata = {16'd0, dc_period_q};
      REG_SERVO_TICKS: prdata = {16'd0, servo_ticks_q};
      default:         prdata = 32'd0;
    endcase
  end

  // Control state
  state_e               state_q, state_d;
  in_word_t             in_q;
  logic [RING_AW-1:0]   ring_idx_q;
  logic [AVG_LENGTH-1:0] ring_vld_q;
  logic [SUM_W-1:0]     sum_a_q, sum_s_q;
  logic [6:0]           held_abs_q, pwm_cnt_q;
  logic [1:0]           dir_q;
  logic                 stby_q, led_q;
  logic                 out_valid_q;
  out_word_t            out_q;

  // Datapath registers
  logic [PROD_W-1:0]    prod_q;
  logic signed [7:0]    speed_q;
  logic [6:0]           abs_speed_q;
  logic [7:0]           abs_angle_q;
  logic [15:0]          servo_q;

  logic                 in_fire, out_free, done_fire;
  logic                 ram_re, ram_we;
  logic [19:0]          ram_rdata;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [PROD_W-1:0]    prod_d;

  assign in_fire   = in_valid_i & ~in_stall_o;
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign done_fire = (state_q == ST_DONE) & out_free;

  // Ring store: {speed, angle} per entry
  msps_ram #(
    .WIDTH(20),
    .DEPTH(AVG_LENGTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ring_idx_q),
    .wdata_i({in_q.chan1_sample, in_q.chan0_sample}),
    .re_i   (ram_re),
    .raddr_i(ring_idx_q),
    .rdata_o(ram_rdata)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ram_re  = (in_word_i.command == CMD_SAMPLE);
          state_d = (in_word_i.command == CMD_SAMPLE) ? ST_UPD : ST_AVG_S;
        end
      end
      ST_UPD: begin
        ram_we  = 1'b1;
        state_d = ST_AVG_S;
      end
      ST_AVG_S: state_d = ST_SCL_S;
      ST_SCL_S: state_d = ST_AVG_A;
      ST_AVG_A: state_d = ST_SCL_A;
      ST_SCL_A: state_d = ST_TPD;
      ST_TPD:   state_d = ST_SERVO;
      ST_SERVO: state_d = ST_DC1;
      ST_DC1:   state_d = ST_DC2;
      ST_DC2:   state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) in_q <= in_word_i;
  end

  // Ring read-modify-write; the read in idle and the write in the next
  // step never overlap another item, so no forwarding is needed.
  logic [9:0]         old_a, old_s;
  logic [RING_AW-1:0] idx_next;

  assign old_a    = ring_vld_q[ring_idx_q] ? ram_rdata[9:0]   : 10'd0;
  assign old_s    = ring_vld_q[ring_idx_q] ? ram_rdata[19:10] : 10'd0;
  assign idx_next = (ring_idx_q == RING_AW'(AVG_LENGTH - 1)) ? '0 : ring_idx_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_idx_q <= '0;
      ring_vld_q <= '0;
      sum_a_q    <= '0;
      sum_s_q    <= '0;
    end else if (ram_we) begin
      ring_idx_q             <= idx_next;
      ring_vld_q[ring_idx_q] <= 1'b1;
      sum_a_q <= sum_a_q - SUM_W'(old_a) + SUM_W'(in_q.chan0_sample);
      sum_s_q <= sum_s_q - SUM_W'(old_s) + SUM_W'(in_q.chan1_sample);
    end
  end

  // Average from the last product, clamped to full scale
  logic [SUM_W-1:0] avg_raw;
  logic [9:0]       avg;

  assign avg_raw = prod_q[AVG_SHIFT+SUM_W-1:AVG_SHIFT];
  assign avg     = (avg_raw > SUM_W'(ADC_FULL_SCALE)) ? ADC_MAX : avg_raw[9:0];

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_AVG_S: begin mul_a = MUL_W'(sum_s_q);       mul_b = MUL_W'(RECIP_AVG);   end
      ST_SCL_S: begin mul_a = MUL_W'(avg);           mul_b = MUL_W'(SPEED_SPAN);  end
      ST_AVG_A: begin mul_a = MUL_W'(sum_a_q);       mul_b = MUL_W'(RECIP_AVG);   end
      ST_SCL_A: begin mul_a = MUL_W'(avg);           mul_b = MUL_W'(ANGLE_SPAN);  end
      ST_TPD:   begin mul_a = MUL_W'(servo_ticks_q); mul_b = MUL_W'(RECIP_ANGLE); end
      ST_SERVO: begin
        mul_a = MUL_W'(prod_q[TICK_SHIFT+8:TICK_SHIFT]);
        mul_b = MUL_W'(abs_angle_q);
      end
      ST_DC1:   begin mul_a = MUL_W'(abs_speed_q);   mul_b = MUL_W'(dc_period_q); end
      ST_DC2:   begin mul_a = MUL_W'(prod_q[22:0]);  mul_b = MUL_W'(RECIP_DC);    end
      default: ;
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Product held during the final step so a stalled result keeps dc
  always_ff @(posedge clk_i) begin
    if (state_q != ST_DONE) prod_q <= prod_d;
  end

  // Setpoints from scaled averages
  logic [SCALE_W-ADC_BITS:0] scaled_q;
  logic signed [9:0]         speed_diff;
  logic signed [7:0]         speed_sat;
  logic [6:0]                speed_abs;

  assign scaled_q   = div_full_scale(prod_q[SCALE_W-1:0]);
  assign speed_diff = $signed(10'(scaled_q)) - SPEED_OFS;

  always_comb begin
    if (speed_diff > 10'sd127)       speed_sat = 8'sd127;
    else if (speed_diff < -10'sd127) speed_sat = -8'sd127;
    else                             speed_sat = speed_diff[7:0];
    speed_abs = speed_sat[7] ? 7'(-speed_sat) : speed_sat[6:0];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_AVG_A: begin
        speed_q     <= speed_sat;
        abs_speed_q <= speed_abs;
      end
      ST_TPD:   abs_angle_q <= (scaled_q > 9'd255) ? 8'd255 : scaled_q[7:0];
      ST_DC1:   servo_q     <= (prod_q[16]) ? 16'hFFFF : prod_q[15:0];
      default: ;
    endcase
  end

  // Held state for direction, standby and the LED soft PWM
  logic [6:0]        held_abs_d, pwm_cnt_d;
  logic [1:0]        dir_d;
  logic              stby_d, led_d;
  logic signed [9:0] angle_diff;
  logic signed [7:0] angle_sat;
  logic [15:0]       dc_sat;

  always_comb begin
    held_abs_d = held_abs_q;
    dir_d      = dir_q;
    stby_d     = stby_q;
    led_d      = led_q;
    pwm_cnt_d  = pwm_cnt_q;
    unique case (in_q.command)
      CMD_SAMPLE: begin
        held_abs_d = abs_speed_q;
        if (speed_q > 8'sd0)      dir_d  = 2'b01;
        else if (speed_q < 8'sd0) dir_d  = 2'b10;
        else                      stby_d = 1'b1;
      end
      CMD_TICK: begin
        led_d     = (held_abs_q > pwm_cnt_q) ? 1'b0 : 1'b1;
        pwm_cnt_d = (pwm_cnt_q >= PWM_LAST) ? 7'd0 : pwm_cnt_q + 7'd1;
      end
      default: ;
    endcase

    angle_diff = $signed({2'b00, abs_angle_q}) - ANGLE_OFS;
    if (angle_diff > 10'sd127)       angle_sat = 8'sd127;
    else if (angle_diff < -10'sd128) angle_sat = -8'sd128;
    else                             angle_sat = angle_diff[7:0];

    dc_sat = prod_q[DC_SHIFT+16] ? 16'hFFFF : prod_q[DC_SHIFT+15:DC_SHIFT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_abs_q <= '0;
      dir_q      <= '0;
      stby_q     <= 1'b0;
      led_q      <= 1'b0;
      pwm_cnt_q  <= '0;
    end else if (done_fire) begin
      held_abs_q <= held_abs_d;
      dir_q      <= dir_d;
      stby_q     <= stby_d;
      led_q      <= led_d;
      pwm_cnt_q  <= pwm_cnt_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)        out_valid_q <= 1'b0;
    else if (done_fire) out_valid_q <= 1'b1;
    else if (out_free)  out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_q.speed_setting <= speed_q;
      out_q.abs_speed     <= abs_speed_q;
      out_q.abs_angle     <= abs_angle_q;
      out_q.angle_setting <= angle_sat;
      out_q.dir_a         <= dir_d[0];
      out_q.dir_b         <= dir_d[1];
      out_q.standby_low   <= stby_d;
      out_q.dc_pulse      <= dc_sat;
      out_q.servo_pulse   <= servo_q;
      out_q.led_on        <= led_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Checks
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_idx_q < RING_AW'(AVG_LENGTH))
    else $error("ring index out of range");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_a_q <= SUM_W'(AVG_LENGTH * ADC_FULL_SCALE)) &&
    (sum_s_q <= SUM_W'(AVG_LENGTH * ADC_FULL_SCALE)))
    else $error("running sum beyond ring capacity");

  a_wr_sets_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> ring_vld_q[$past(ring_idx_q)])
    else $error("ring write left entry invalid");

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result appeared outside final step");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("second word taken while one is in work");

endmodule
